/* sv/assert_macros.svh */
// assertion helpers for the bound checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TKL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TKL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tkl_pkg.sv */
package tkl_pkg;

  // fixed field widths
  localparam int KEY_W      = 63;
  localparam int TAG_PORT_W = 16;
  localparam int IDX_W      = 6;
  localparam int CNT_PORT_W = 7;

  // parameter defaults
  localparam int DEF_KEEP_COUNT = 10;
  localparam int DEF_TAG_BITS   = 16;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // address bits for a table of the given depth
  function automatic int addr_bits(input int depth);
    addr_bits = (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_ROOT_CMP,
    ST_NODE_RD,
    ST_LEFT_RD,
    ST_RIGHT_RD,
    ST_DECIDE,
    ST_SWAP_WR,
    ST_FIN_RD,
    ST_FIN_OUT,
    ST_READ_OUT
  } tkl_state_t;

  // outcome of one node compare
  typedef struct packed {
    logic swap;
    logic take_right;
  } tkl_pick_t;

endpackage

/* sv/tkl_ram.sv */
module tkl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tkl_pick.sv */
module tkl_pick import tkl_pkg::*; (
  input  logic [KEY_W-1:0] node_key,
  input  logic [KEY_W-1:0] left_key,
  input  logic [KEY_W-1:0] right_key,
  input  logic             has_right,
  output tkl_pick_t        pick
);

  logic left_lt;
  logic right_lt_left;
  logic right_lt_node;
  logic right_wins;

  // smallest of node and children, left tested first, strict compares
  assign left_lt       = left_key < node_key;
  assign right_lt_left = right_key < left_key;
  assign right_lt_node = right_key < node_key;
  assign right_wins    = has_right && (left_lt ? right_lt_left : right_lt_node);

  assign pick.swap       = left_lt || right_wins;
  assign pick.take_right = right_wins;

endmodule

/* sv/top_k_largest_tracker_unit.sv */
// channel   ports                                        transfer
// input     start, busy, in_kind/new_key/new_tag/read_index   start && !busy
// result    out_strobe, out_entry_valid/key/tag/count     out_strobe, one cycle
//
// busy stays high while a read fetches its entry and while an insert walks the
// m = floor(count/2) internal nodes, each read through the single read port of the
// heap memory, compared and, where it swaps, written back. starts wait for idle.
// the result strobe is high in the first cycle with busy low; a new start may be
// taken in that same cycle. reset clears fill count, sequencer and strobe;
// heap contents are not cleared. the receiver cannot stall results.
module top_k_largest_tracker_unit import tkl_pkg::*; #(
  parameter int KEEP_COUNT = DEF_KEEP_COUNT,
  parameter int TAG_BITS   = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [KEY_W-1:0]      in_new_key,
  input  logic [TAG_PORT_W-1:0] in_new_tag,
  input  logic [IDX_W-1:0]      in_read_index,
  output logic                  out_strobe,
  output logic                  out_entry_valid,
  output logic [KEY_W-1:0]      out_entry_key,
  output logic [TAG_PORT_W-1:0] out_entry_tag,
  output logic [CNT_PORT_W-1:0] out_entry_count
);

  localparam int ADDR_W = addr_bits(KEEP_COUNT);
  localparam int IW     = ADDR_W + 1;
  localparam int CNT_W  = $clog2(KEEP_COUNT + 1);
  localparam int DW     = KEY_W + TAG_BITS;

  tkl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] node_r, node_nxt;
  logic [ADDR_W-1:0] best_idx_r, best_idx_nxt;
  logic [DW-1:0]     new_data_r, new_data_nxt;
  logic [DW-1:0]     node_data_r, node_data_nxt;
  logic [DW-1:0]     left_data_r, left_data_nxt;
  logic              hit_r, hit_nxt;

  logic                  out_strobe_r, out_strobe_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]      out_key_r, out_key_nxt;
  logic [TAG_PORT_W-1:0] out_tag_r, out_tag_nxt;
  logic [CNT_PORT_W-1:0] out_count_r, out_count_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DW-1:0]     wdata;
  logic [ADDR_W-1:0] raddr;
  logic [DW-1:0]     rdata;

  logic              accept;
  logic              full;
  logic              read_hit;
  logic [ADDR_W-1:0] cur_idx;
  logic [IW-1:0]     left_idx;
  logic [IW-1:0]     right_idx;
  logic              has_right;
  tkl_pick_t         pick;

  // heap storage, key above tag
  tkl_ram #(
    .WIDTH (DW),
    .DEPTH (KEEP_COUNT)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // node compare
  tkl_pick u_pick (
    .node_key  (node_data_r[TAG_BITS +: KEY_W]),
    .left_key  (left_data_r[TAG_BITS +: KEY_W]),
    .right_key (rdata[TAG_BITS +: KEY_W]),
    .has_right (has_right),
    .pick      (pick)
  );

  // index arithmetic for the node under work
  assign accept    = start && !busy;
  assign full      = fill_r == CNT_W'(KEEP_COUNT);
  assign read_hit  = {1'b0, in_read_index} < CNT_PORT_W'(fill_r);
  assign cur_idx   = node_r - ADDR_W'(1);
  assign left_idx  = {cur_idx, 1'b1};
  assign right_idx = left_idx + IW'(1);
  assign has_right = right_idx < IW'(fill_r);
  assign busy      = state_r != ST_IDLE;

  // sequencer state and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    best_idx_r  <= best_idx_nxt;
    new_data_r  <= new_data_nxt;
    node_data_r <= node_data_nxt;
    left_data_r <= left_data_nxt;
    hit_r       <= hit_nxt;
    out_valid_r <= out_valid_nxt;
    out_key_r   <= out_key_nxt;
    out_tag_r   <= out_tag_nxt;
    out_count_r <= out_count_nxt;
  end

  // next state, memory ports and result
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    node_nxt       = node_r;
    best_idx_nxt   = best_idx_r;
    new_data_nxt   = new_data_r;
    node_data_nxt  = node_data_r;
    left_data_nxt  = left_data_r;
    hit_nxt        = hit_r;
    out_strobe_nxt = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    out_count_nxt  = out_count_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = new_data_r;
    raddr          = '0;

    case (state_r)
      ST_IDLE: begin
        raddr = (in_kind == KIND_READ) ? in_read_index[ADDR_W-1:0] : '0;
        if (accept) begin
          new_data_nxt = {in_new_key, TAG_BITS'(in_new_tag)};
          hit_nxt      = read_hit;
          if (in_kind == KIND_READ) begin
            state_nxt = ST_READ_OUT;
          end else if (full) begin
            state_nxt = ST_ROOT_CMP;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        we        = 1'b1;
        waddr     = ADDR_W'(fill_r);
        fill_nxt  = fill_r + CNT_W'(1);
        node_nxt  = ADDR_W'(({1'b0, fill_r} + (CNT_W + 1)'(1)) >> 1);
        state_nxt = (node_nxt != '0) ? ST_NODE_RD : ST_FIN_RD;
      end
      ST_ROOT_CMP: begin
        // root replaced only by a strictly greater key
        we        = new_data_r[TAG_BITS +: KEY_W] > rdata[TAG_BITS +: KEY_W];
        waddr     = '0;
        node_nxt  = ADDR_W'(fill_r >> 1);
        state_nxt = (node_nxt != '0) ? ST_NODE_RD : ST_FIN_RD;
      end
      ST_NODE_RD: begin
        raddr     = cur_idx;
        state_nxt = ST_LEFT_RD;
      end
      ST_LEFT_RD: begin
        raddr         = left_idx[ADDR_W-1:0];
        node_data_nxt = rdata;
        state_nxt     = ST_RIGHT_RD;
      end
      ST_RIGHT_RD: begin
        raddr         = has_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        left_data_nxt = rdata;
        state_nxt     = ST_DECIDE;
      end
      ST_DECIDE: begin
        // smaller child moves up, node goes down next cycle
        we           = pick.swap;
        waddr        = cur_idx;
        wdata        = pick.take_right ? rdata : left_data_r;
        best_idx_nxt = pick.take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        if (pick.swap) begin
          state_nxt = ST_SWAP_WR;
        end else begin
          node_nxt  = node_r - ADDR_W'(1);
          state_nxt = (node_r == ADDR_W'(1)) ? ST_FIN_RD : ST_NODE_RD;
        end
      end
      ST_SWAP_WR: begin
        we        = 1'b1;
        waddr     = best_idx_r;
        wdata     = node_data_r;
        node_nxt  = node_r - ADDR_W'(1);
        state_nxt = (node_r == ADDR_W'(1)) ? ST_FIN_RD : ST_NODE_RD;
      end
      ST_FIN_RD: begin
        raddr     = '0;
        state_nxt = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        out_strobe_nxt = 1'b1;
        out_valid_nxt  = 1'b1;
        out_key_nxt    = rdata[TAG_BITS +: KEY_W];
        out_tag_nxt    = TAG_PORT_W'(rdata[TAG_BITS-1:0]);
        out_count_nxt  = CNT_PORT_W'(fill_r);
        state_nxt      = ST_IDLE;
      end
      ST_READ_OUT: begin
        // entries at or above the fill count read as zero
        out_strobe_nxt = 1'b1;
        out_valid_nxt  = hit_r;
        out_key_nxt    = hit_r ? rdata[TAG_BITS +: KEY_W] : '0;
        out_tag_nxt    = hit_r ? TAG_PORT_W'(rdata[TAG_BITS-1:0]) : '0;
        out_count_nxt  = CNT_PORT_W'(fill_r);
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result ports
  assign out_strobe      = out_strobe_r;
  assign out_entry_valid = out_valid_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_tag   = out_tag_r;
  assign out_entry_count = out_count_r;

endmodule

/* sv/tkl_chk.sv */
`include "assert_macros.svh"

module tkl_chk import tkl_pkg::*; #(
  parameter int KEEP_COUNT = DEF_KEEP_COUNT
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_strobe,
  input logic                  out_entry_valid,
  input logic [KEY_W-1:0]      out_entry_key,
  input logic [TAG_PORT_W-1:0] out_entry_tag,
  input logic [CNT_PORT_W-1:0] out_entry_count
);

  // a transfer in always occupies the block
  `TKL_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy did not rise after transfer")

  // results only appear once the work is done
  `TKL_ASSERT_IMP(a_strobe_idle, out_strobe, !busy, "result shown while busy")

  // one strobe cycle per item
  `TKL_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held two cycles")

  // missing entries read as zero
  `TKL_ASSERT_IMP(a_miss_zero, out_strobe && !out_entry_valid,
    out_entry_key == '0 && out_entry_tag == '0, "missing entry not zero")

  // fill count never passes the heap size
  `TKL_ASSERT_IMP(a_count_max, out_strobe,
    out_entry_count <= CNT_PORT_W'(KEEP_COUNT), "count above heap size")

endmodule

bind top_k_largest_tracker_unit tkl_chk #(.KEEP_COUNT(KEEP_COUNT)) u_tkl_chk (.*);

/* tb/top_k_entry_checker.sv */
`timescale 1ns / 100ps

// watches both channels, keeps its own copy of the heap and checks every result
module top_k_entry_checker import tkl_pkg::*; #(
  parameter int KEEP_COUNT = DEF_KEEP_COUNT,
  parameter int TAG_BITS   = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_kind,
  input  logic [KEY_W-1:0]      in_new_key,
  input  logic [TAG_PORT_W-1:0] in_new_tag,
  input  logic [IDX_W-1:0]      in_read_index,
  input  logic                  out_strobe,
  input  logic                  out_entry_valid,
  input  logic [KEY_W-1:0]      out_entry_key,
  input  logic [TAG_PORT_W-1:0] out_entry_tag,
  input  logic [CNT_PORT_W-1:0] out_entry_count,
  output int                    fail_count,
  output int                    pending
);

  // tag bits that the block keeps
  localparam logic [TAG_PORT_W-1:0] TAG_KEEP =
    (TAG_BITS >= TAG_PORT_W) ? '1 : TAG_PORT_W'((1 << TAG_BITS) - 1);

  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [TAG_PORT_W-1:0] tag;
    logic [CNT_PORT_W-1:0] count;
  } entry_result_t;

  // shadow heap
  logic [KEY_W-1:0]      heap_key [KEEP_COUNT];
  logic [TAG_PORT_W-1:0] heap_tag [KEEP_COUNT];
  int                    held = 0;

  entry_result_t expected_entries [$];
  int fault_total = 0;
  int outstanding = 0;

  assign fail_count = fault_total;
  assign pending    = outstanding;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    fault_total++;
  endtask

  // apply one item to the shadow heap and return the entry it should produce
  function automatic entry_result_t predict_entry(input logic kind,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [TAG_PORT_W-1:0] tag,
                                                  input logic [IDX_W-1:0] idx);
    entry_result_t         res;
    int                    node;
    int                    least;
    int                    lc;
    int                    rc;
    logic [KEY_W-1:0]      k_tmp;
    logic [TAG_PORT_W-1:0] t_tmp;
    res = '0;
    if (kind == KIND_INSERT) begin
      // append while room remains, else replace a strictly smaller root
      if (held < KEEP_COUNT) begin
        heap_key[held] = key;
        heap_tag[held] = tag & TAG_KEEP;
        held++;
      end else if (key > heap_key[0]) begin
        heap_key[0] = key;
        heap_tag[0] = tag & TAG_KEEP;
      end
      // one bottom-up pass, left child tested before right, strict compares
      for (node = held / 2 - 1; node >= 0; node--) begin
        least = node;
        lc    = 2 * node + 1;
        rc    = 2 * node + 2;
        if (lc < held && heap_key[lc] < heap_key[least]) least = lc;
        if (rc < held && heap_key[rc] < heap_key[least]) least = rc;
        if (least != node) begin
          k_tmp           = heap_key[node];
          t_tmp           = heap_tag[node];
          heap_key[node]  = heap_key[least];
          heap_tag[node]  = heap_tag[least];
          heap_key[least] = k_tmp;
          heap_tag[least] = t_tmp;
        end
      end
      res.valid = 1'b1;
      res.key   = heap_key[0];
      res.tag   = heap_tag[0];
    end else if (int'(idx) < held) begin
      res.valid = 1'b1;
      res.key   = heap_key[idx];
      res.tag   = heap_tag[idx];
    end
    res.count = CNT_PORT_W'(held);
    return res;
  endfunction

  // check results against the oldest expectation, then queue new transfers
  always @(posedge clk) begin : watch
    entry_result_t want;
    if (!rst_n) begin
      held = 0;
      expected_entries.delete();
    end else begin
      if (out_strobe) begin
        if (expected_entries.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(out_entry_key), 64'd0);
        end else begin
          want = expected_entries.pop_front();
          if (out_entry_valid !== want.valid)
            report_mismatch("entry_valid", 64'(out_entry_valid), 64'(want.valid));
          if (out_entry_key !== want.key)
            report_mismatch("entry_key", 64'(out_entry_key), 64'(want.key));
          if (out_entry_tag !== want.tag)
            report_mismatch("entry_tag", 64'(out_entry_tag), 64'(want.tag));
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", 64'(out_entry_count), 64'(want.count));
        end
      end
      if (start && !busy)
        expected_entries.push_back(predict_entry(in_kind, in_new_key, in_new_tag,
                                                 in_read_index));
    end
    outstanding <= expected_entries.size();
  end

endmodule

/* tb/tb_top_k_largest_tracker_unit.sv */
`timescale 1ns / 100ps

module tb_top_k_largest_tracker_unit;
  import tkl_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int BAND_ITEMS   = 225;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic                  in_kind       = KIND_INSERT;
  logic [KEY_W-1:0]      in_new_key    = '0;
  logic [TAG_PORT_W-1:0] in_new_tag    = '0;
  logic [IDX_W-1:0]      in_read_index = '0;
  logic                  busy;
  logic                  out_strobe;
  logic                  out_entry_valid;
  logic [KEY_W-1:0]      out_entry_key;
  logic [TAG_PORT_W-1:0] out_entry_tag;
  logic [CNT_PORT_W-1:0] out_entry_count;

  int fault_total;
  int outstanding;
  int cycle_count = 0;
  logic [KEY_W-1:0] last_key = '0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  top_k_largest_tracker_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_new_key      (in_new_key),
    .in_new_tag      (in_new_tag),
    .in_read_index   (in_read_index),
    .out_strobe      (out_strobe),
    .out_entry_valid (out_entry_valid),
    .out_entry_key   (out_entry_key),
    .out_entry_tag   (out_entry_tag),
    .out_entry_count (out_entry_count)
  );

  top_k_entry_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_new_key      (in_new_key),
    .in_new_tag      (in_new_tag),
    .in_read_index   (in_read_index),
    .out_strobe      (out_strobe),
    .out_entry_valid (out_entry_valid),
    .out_entry_key   (out_entry_key),
    .out_entry_tag   (out_entry_tag),
    .out_entry_count (out_entry_count),
    .fail_count      (fault_total),
    .pending         (outstanding)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top_k_largest_tracker_unit: done, errors");
      $finish;
    end
  end

  // one transfer on the input channel, after a random gap unless in a burst
  task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
                           input logic [TAG_PORT_W-1:0] tag,
                           input logic [IDX_W-1:0] idx, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_kind       <= kind;
    in_new_key    <= key;
    in_new_tag    <= tag;
    in_read_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic insert_key(input logic [KEY_W-1:0] key, input logic [TAG_PORT_W-1:0] tag);
    send_item(KIND_INSERT, key, tag, IDX_W'($urandom), 1'b0);
  endtask

  task automatic read_slot(input logic [IDX_W-1:0] idx);
    send_item(KIND_READ, KEY_W'({$urandom, $urandom}), TAG_PORT_W'($urandom), idx, 1'b0);
  endtask

  // stop sending until every queued result has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // keys in rising bands so the heap keeps turning over; widths vary for ties
  function automatic logic [KEY_W-1:0] draw_key(input int band);
    logic [63:0] raw;
    logic [59:0] low;
    int          width;
    int          pick;
    raw   = {$urandom, $urandom};
    width = $urandom_range(1, 60);
    pick  = $urandom_range(0, 19);
    low   = raw[59:0] & ((60'd1 << width) - 60'd1);
    if (pick == 0 && band == 7)
      return KEY_MAX;
    if (pick == 1)
      return last_key;
    if (pick < 4 && band > 0)
      return {3'(band - 1), raw[59:0]};
    return {3'(band), low};
  endfunction

  initial begin : stimulus
    int               i;
    int               band;
    bit               burst;
    logic [KEY_W-1:0] key;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reads of an empty heap
    read_slot(6'd0);
    read_slot(6'd63);
    // extreme keys and tags, then reads in and past the fill
    insert_key(KEY_MAX, 16'hffff);
    insert_key('0, 16'h0000);
    read_slot(6'd1);
    read_slot(6'd2);
    // equal keys exercise the strict compares and left-first choice
    insert_key(63'd7, 16'h1111);
    insert_key(63'd7, 16'h2222);
    insert_key(63'd7, 16'h3333);
    insert_key(63'd3, 16'h4444);
    insert_key(63'd7, 16'h5555);
    insert_key(63'd50, 16'h6666);
    insert_key(63'd9, 16'h7777);
    insert_key(63'd1, 16'h8888);
    // full: equal to root is dropped, larger replaces it
    insert_key('0, 16'h9999);
    insert_key(63'd1, 16'haaaa);
    insert_key(KEY_MAX, 16'h5a5a);
    read_slot(6'd9);
    read_slot(6'd10);
    read_slot(6'd63);

    // random part
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      band  = i / BAND_ITEMS;
      burst = (i % 150) < 20;
      if (i == RANDOM_ITEMS / 2)
        hold_until_drained();
      if ($urandom_range(0, 9) < 6) begin
        key      = draw_key(band);
        last_key = key;
        send_item(KIND_INSERT, key, TAG_PORT_W'($urandom), IDX_W'($urandom), burst);
      end else begin
        send_item(KIND_READ, KEY_W'({$urandom, $urandom}), TAG_PORT_W'($urandom),
                  ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 63))
                                              : IDX_W'($urandom_range(0, 11)),
                  burst);
      end
    end

    // wait out the last results, then a little more for strays
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_total == 0)
      $display("tb_top_k_largest_tracker_unit: done, clean");
    else
      $display("tb_top_k_largest_tracker_unit: done, errors");
    $finish;
  end

endmodule
